// ===== hw/rtl/psdp_pkg.sv =====
// Package: shared types, constants and the arctangent table of the phasor block.
package psdp_pkg;

  localparam int PHASE_BITS_DEF        = 32;
  localparam int SINCOS_ITERATIONS_DEF = 16;
  localparam int ATAN_STEPS            = 24;

  localparam int CORDIC_W = 34;          // x, y, z datapath width
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [31:0] PHASE_SCALE_RST = 32'd268435456;
  localparam logic [31:0] DELTA_RATIO_RST = 32'd0;

  localparam logic [1:0] REG_PHASE_SCALE  = 2'd0;
  localparam logic [1:0] REG_DELTA_RATIO  = 2'd1;
  localparam logic [1:0] REG_DELTA_ENABLE = 2'd2;

  typedef struct packed {
    logic signed [31:0] u_meters;
    logic signed [31:0] v_meters;
    logic signed [31:0] w_meters;
    logic signed [31:0] l_cosine;
    logic signed [31:0] m_cosine;
    logic signed [31:0] n_cosine;
  } item_t;

  typedef struct packed {
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
    logic signed [15:0] delta_re;
    logic signed [15:0] delta_im;
  } result_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/psdp_cordic.sv =====
// Pipelined CORDIC: 32-bit turn angle to Q1.15 cos/sin, one stage per iteration.
module psdp_cordic #(
  parameter int ITERATIONS = psdp_pkg::SINCOS_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic        [31:0] angle,
  output logic signed [15:0] re,
  output logic signed [15:0] im
);
  import psdp_pkg::*;

  localparam int N = (ITERATIONS < ATAN_STEPS) ? ITERATIONS : ATAN_STEPS;

  logic signed [CORDIC_W-1:0] x [0:N];
  logic signed [CORDIC_W-1:0] y [0:N];
  logic signed [CORDIC_W-1:0] z [0:N];
  logic        [1:0]          q [0:N];

  logic [31:0] ang_off;
  logic [1:0]  quad;
  logic [31:0] ang_red;

  assign ang_off = angle + 32'h2000_0000;
  assign quad    = ang_off[31:30];
  assign ang_red = angle - {quad, 30'd0};

  // entry stage: quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CORDIC_GAIN_Q30;
      y[0] <= '0;
      z[0] <= CORDIC_W'($signed(ang_red));
      q[0] <= quad;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    localparam logic signed [CORDIC_W-1:0] ATAN_K =
      $signed({{(CORDIC_W-32){1'b0}}, atan_turns(k)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[k][CORDIC_W-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - ATAN_K;
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + ATAN_K;
        end
        q[k+1] <= q[k];
      end
    end
  end

  logic signed [CORDIC_W-1:0] c_val, s_val;

  always_comb begin
    case (q[N])
      2'd0: begin c_val = x[N];  s_val = y[N];  end
      2'd1: begin c_val = -y[N]; s_val = x[N];  end
      2'd2: begin c_val = -x[N]; s_val = -y[N]; end
      default: begin c_val = y[N]; s_val = -x[N]; end
    endcase
  end

  function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W:0]    sum;
    logic signed [CORDIC_W-15:0] r;
    sum = {v[CORDIC_W-1], v} + (CORDIC_W+1)'(16384);
    r   = (CORDIC_W-14)'(sum >>> 15);
    if (r > 32767)       return 16'sh7fff;
    else if (r < -32768) return 16'sh8000;
    else                 return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      re <= to_q15(c_val);
      im <= to_q15(s_val);
    end
  end

endmodule

// ===== hw/rtl/point_source_dft_phasor.sv =====
// Top level: station-to-source phase factor, phase and delta phasor per transaction.
// Throughput: one transaction per cycle unless the result stalls; six arithmetic
//   stages, then one CORDIC stage per iteration, two CORDIC lanes side by side.
// A stalled result freezes the whole pipeline; bubbles stay in place.
// Reset (rst, synchronous) empties the pipeline and restores register defaults.
module point_source_dft_phasor #(
  parameter int PHASE_BITS        = psdp_pkg::PHASE_BITS_DEF,
  parameter int SINCOS_ITERATIONS = psdp_pkg::SINCOS_ITERATIONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  psdp_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output psdp_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import psdp_pkg::*;

  localparam int N   = (SINCOS_ITERATIONS < ATAN_STEPS) ? SINCOS_ITERATIONS : ATAN_STEPS;
  localparam int LAT = 8 + N;
  // low turn-angle bits dropped when the phase is kept to fewer than 32 bits
  localparam int MASKB = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF << MASKB;

  // ---------------- configuration registers ----------------
  logic [31:0] phase_scale;
  logic [31:0] delta_ratio;
  logic        delta_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_scale  <= PHASE_SCALE_RST;
      delta_ratio  <= DELTA_RATIO_RST;
      delta_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_SCALE:  phase_scale  <= cfg_data;
        REG_DELTA_RATIO:  delta_ratio  <= cfg_data;
        REG_DELTA_ENABLE: delta_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // One global advance enable: the pipe moves unless the output register
  // holds a transaction that the sink refuses.
  logic           en;
  logic [LAT-1:0] vld;

  assign en           = !(vld[LAT-1] && result_stall);
  assign item_stall   = !en;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  // ---------------- stage 1: coordinate products ----------------
  logic signed [32:0] n_minus_one;
  logic signed [63:0] prod_u, prod_v;
  logic signed [64:0] prod_w;

  assign n_minus_one = 33'(item.n_cosine) - 33'sd1073741824;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_u <= item.u_meters * item.l_cosine;
      prod_v <= item.v_meters * item.m_cosine;
      prod_w <= 65'(item.w_meters) * 65'(n_minus_one);
    end
  end

  // ---------------- stage 2: geometric delay, 38 fraction bits ----------------
  logic signed [67:0] delay_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      delay_sum <= 68'(prod_u) + 68'(prod_v) + 68'(prod_w);
    end
  end

  // ---------------- stage 3: phase partial products ----------------
  // delay (68 bits) split into an unsigned low half and a signed high half
  logic        [65:0] ph_lo;
  logic signed [66:0] ph_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_lo <= delay_sum[33:0] * phase_scale;
      ph_hi <= $signed(delay_sum[67:34]) * $signed({1'b0, phase_scale});
    end
  end

  // ---------------- stage 4: phase in turns, 66 fraction bits ----------------
  logic [127:0] phase;

  always_ff @(posedge clk) begin
    if (en) begin
      phase <= {62'd0, ph_lo} + (128'($signed(ph_hi)) << 34);
    end
  end

  // ---------------- stage 5: delta partial products ----------------
  logic [63:0] dp [0:3];
  logic [31:0] ang_value_s5;

  for (genvar c = 0; c < 4; c++) begin : g_dpart
    always_ff @(posedge clk) begin
      if (en) begin
        dp[c] <= phase[32*c +: 32] * delta_ratio;
      end
    end
  end

  // top 32 fraction bits of the phase: a 2^-32 turn angle
  always_ff @(posedge clk) begin
    if (en) begin
      ang_value_s5 <= phase[65:34];
    end
  end

  // ---------------- stage 6: turn angles ----------------
  logic [127:0] delta_phase;
  logic [31:0]  ang_value, ang_delta;

  assign delta_phase = {64'd0, dp[0]} + ({64'd0, dp[1]} << 32)
                     + ({64'd0, dp[2]} << 64) + ({64'd0, dp[3]} << 96);

  // delta phase carries 94 fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      ang_value <= ang_value_s5 & ANG_MASK;
      ang_delta <= delta_phase[93:62] & ANG_MASK;
    end
  end

  // ---------------- CORDIC lanes ----------------
  logic signed [15:0] v_re, v_im, d_re, d_im;

  psdp_cordic #(.ITERATIONS(N)) u_cordic_value (
    .clk   (clk),
    .en    (en),
    .angle (ang_value),
    .re    (v_re),
    .im    (v_im)
  );

  psdp_cordic #(.ITERATIONS(N)) u_cordic_delta (
    .clk   (clk),
    .en    (en),
    .angle (ang_delta),
    .re    (d_re),
    .im    (d_im)
  );

  // delta zero when disabled; user must change registers only while idle, unenforced
  assign result.value_re = v_re;
  assign result.value_im = v_im;
  assign result.delta_re = delta_enable ? d_re : 16'sd0;
  assign result.delta_im = delta_enable ? d_im : 16'sd0;

  // ---------------- assertions ----------------
  a_reset_empties: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("pipeline not empty after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled while output free");

  a_delta_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !delta_enable) |-> (result.delta_re == 16'sd0 && result.delta_im == 16'sd0))
    else $error("delta phasor nonzero while disabled");

endmodule
